### sv/vrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the voxel ray traversal block.
package vrt_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIR_BITS = 14;
  localparam int ORG_W = 24;
  localparam int DIR_W = 16;
  localparam int REACH_W = 23;
  localparam int IDX_W = 6;
  localparam logic [REACH_W-1:0] REACH_RESET = 23'd327680;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [2:0] DIV_LAST = 3'd5;
  localparam logic [1:0] AX_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DLOAD,
    S_DIV,
    S_STEP,
    S_READ,
    S_TEST,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clr_step;
    logic       wr_voxel;
    logic       cast_load;
    logic       div_load;
    logic       div_step;
    logic [2:0] div_idx;
    logic       walk_step;
    logic       mem_read;
    logic       test;
    logic       mul;
    logic       add;
    logic [1:0] ax;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic walk_stop;
    logic is_hit;
  } stat_t;

endpackage

### sv/vrt_datapath.sv
`timescale 1ns / 1ps
// Datapath: occupancy memory, shared divider, voxel walker and hit point unit.
module vrt_datapath import vrt_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic [IDX_W-1:0]        in_voxel_x,
  input  logic [IDX_W-1:0]        in_voxel_y,
  input  logic [IDX_W-1:0]        in_voxel_z,
  input  logic                    in_solid,
  input  logic signed [ORG_W-1:0] in_origin_x,
  input  logic signed [ORG_W-1:0] in_origin_y,
  input  logic signed [ORG_W-1:0] in_origin_z,
  input  logic signed [DIR_W-1:0] in_dir_x,
  input  logic signed [DIR_W-1:0] in_dir_y,
  input  logic signed [DIR_W-1:0] in_dir_z,
  input  logic                    cfg_wr_en,
  input  logic [REACH_W-1:0]      cfg_wr_data,
  output logic                    out_hit,
  output logic [IDX_W-1:0]        out_block_x,
  output logic [IDX_W-1:0]        out_block_y,
  output logic [IDX_W-1:0]        out_block_z,
  output logic [1:0]              out_normal_axis,
  output logic                    out_normal_negative,
  output logic signed [ORG_W-1:0] out_hit_x,
  output logic signed [ORG_W-1:0] out_hit_y,
  output logic signed [ORG_W-1:0] out_hit_z
);

  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW = $clog2(CELLS);
  localparam int GW = $clog2(GRID_SIZE);
  localparam int NW = FRACTION_BITS + DIR_BITS + 1;
  localparam int CW = $clog2(NW);
  localparam int RW = DIR_W + 1;
  localparam int TW = ((NW > REACH_W) ? NW : REACH_W) + 1;
  localparam int BW = 2 * (ORG_W - FRACTION_BITS) + 9;
  localparam int PW = DIR_W + REACH_W + 1;
  localparam logic signed [PW:0] HMAX = $signed((PW + 1)'(2 ** (ORG_W - 1) - 1));
  localparam logic signed [PW:0] HMIN = -HMAX - (PW + 1)'(1);
  localparam logic signed [PW:0] HALF = $signed((PW + 1)'(2 ** (DIR_BITS - 1)));

  logic mem [CELLS];
  logic [AW-1:0] clr_r;
  logic mem_q_r;
  logic ingrid_r;

  logic [REACH_W-1:0] reach_r;
  logic signed [ORG_W-1:0] org_r [3];
  logic signed [DIR_W-1:0] dir_r [3];
  logic signed [BW-1:0] blk_r [3];
  logic [TW-1:0] tmax_r [3];
  logic [TW-1:0] tdel_r [3];
  logic [1:0] a_r;
  logic [REACH_W-1:0] dist_r;
  logic res_hit_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ORG_W-1:0] hp_r [3];

  logic [NW-1:0] dq_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] bit_r;

  logic [1:0] dax;
  logic [FRACTION_BITS-1:0] frac;
  logic [FRACTION_BITS:0] upfrac;
  logic [DIR_W-1:0] absd;
  logic [NW-1:0] num;
  logic [RW-1:0] shifted;
  logic ge;
  logic [RW-1:0] rem_nxt;
  logic [NW-1:0] dq_nxt;

  logic [2:0] fin;
  logic n01, n02, n12, none;
  logic [1:0] a_sel;
  logic [TW-1:0] dist_sel;

  logic ingrid;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic wr_ok;
  logic signed [PW:0] p;
  logic signed [PW:0] h;
  logic signed [ORG_W-1:0] h_sat;

  always_comb begin
    dax = cmd.div_idx[2:1];
    frac = org_r[dax][FRACTION_BITS-1:0];
    upfrac = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};
    absd = (dir_r[dax] < 0) ? DIR_W'(-dir_r[dax]) : DIR_W'(dir_r[dax]);
    if (cmd.div_idx[0]) begin
      num = {1'b1, {(NW - 1){1'b0}}};
    end else if (dir_r[dax] > 0) begin
      num = {upfrac, {DIR_BITS{1'b0}}};
    end else begin
      num = {1'b0, frac, {DIR_BITS{1'b0}}};
    end
    shifted = {rem_r[RW-2:0], dq_r[NW-1]};
    ge = shifted >= {1'b0, absd};
    rem_nxt = ge ? (shifted - {1'b0, absd}) : shifted;
    dq_nxt = {dq_r[NW-2:0], ge};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fin[k] = dir_r[k] != 0;
    end
    n01 = fin[0] && (!fin[1] || tmax_r[0] < tmax_r[1]);
    n02 = fin[0] && (!fin[2] || tmax_r[0] < tmax_r[2]);
    n12 = fin[1] && (!fin[2] || tmax_r[1] < tmax_r[2]);
    none = 1'b0;
    priority if (n01 && n02) begin
      a_sel = 2'd0;
    end else if (n12) begin
      a_sel = 2'd1;
    end else if (fin[2]) begin
      a_sel = 2'd2;
    end else begin
      a_sel = 2'd0;
      none = 1'b1;
    end
    dist_sel = tmax_r[a_sel];
  end

  always_comb begin
    ingrid = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (blk_r[k] < 0 || blk_r[k] >= BW'(GRID_SIZE)) begin
        ingrid = 1'b0;
      end
    end
    raddr = AW'(blk_r[0][GW-1:0]) * AW'(GRID_SIZE * GRID_SIZE)
          + AW'(blk_r[1][GW-1:0]) * AW'(GRID_SIZE) + AW'(blk_r[2][GW-1:0]);
    waddr = AW'(in_voxel_x) * AW'(GRID_SIZE * GRID_SIZE)
          + AW'(in_voxel_y) * AW'(GRID_SIZE) + AW'(in_voxel_z);
    wr_ok = (32'(in_voxel_x) < GRID_SIZE) && (32'(in_voxel_y) < GRID_SIZE)
         && (32'(in_voxel_z) < GRID_SIZE);
    p = (PW + 1)'(prod_r) + HALF;
    h = (p >>> DIR_BITS) + (PW + 1)'(org_r[cmd.ax]);
    if (h > HMAX) begin
      h_sat = HMAX[ORG_W-1:0];
    end else if (h < HMIN) begin
      h_sat = HMIN[ORG_W-1:0];
    end else begin
      h_sat = h[ORG_W-1:0];
    end
  end

  always_comb begin
    stat.clr_last = clr_r == AW'(CELLS - 1);
    stat.div_last = bit_r == CW'(NW - 1);
    stat.walk_stop = none || (dist_sel > TW'(reach_r));
    stat.is_hit = mem_q_r & ingrid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      reach_r <= REACH_RESET;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_wr_en) begin
        reach_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_r] <= 1'b0;
    end else if (cmd.wr_voxel && wr_ok) begin
      mem[waddr] <= in_solid;
    end
    if (cmd.mem_read) begin
      mem_q_r <= mem[raddr];
      ingrid_r <= ingrid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cast_load) begin
      org_r[0] <= in_origin_x;
      org_r[1] <= in_origin_y;
      org_r[2] <= in_origin_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
      blk_r[0] <= BW'(in_origin_x >>> FRACTION_BITS);
      blk_r[1] <= BW'(in_origin_y >>> FRACTION_BITS);
      blk_r[2] <= BW'(in_origin_z >>> FRACTION_BITS);
      res_hit_r <= 1'b0;
    end
    if (cmd.div_load) begin
      dq_r <= num;
      rem_r <= '0;
      bit_r <= '0;
    end else if (cmd.div_step) begin
      dq_r <= dq_nxt;
      rem_r <= rem_nxt;
      bit_r <= bit_r + CW'(1);
      if (stat.div_last) begin
        if (cmd.div_idx[0]) begin
          tdel_r[dax] <= TW'(dq_nxt);
        end else begin
          tmax_r[dax] <= TW'(dq_nxt);
        end
      end
    end
    if (cmd.walk_step) begin
      blk_r[a_sel] <= (dir_r[a_sel] > 0) ? blk_r[a_sel] + BW'(1) : blk_r[a_sel] - BW'(1);
      tmax_r[a_sel] <= dist_sel + tdel_r[a_sel];
      a_r <= a_sel;
      dist_r <= dist_sel[REACH_W-1:0];
    end
    if (cmd.test && stat.is_hit) begin
      res_hit_r <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= PW'(dir_r[cmd.ax] * $signed({1'b0, dist_r}));
    end
    if (cmd.add) begin
      hp_r[cmd.ax] <= h_sat;
    end
    if (cmd.out_load) begin
      out_hit <= res_hit_r;
      out_block_x <= res_hit_r ? blk_r[0][IDX_W-1:0] : '0;
      out_block_y <= res_hit_r ? blk_r[1][IDX_W-1:0] : '0;
      out_block_z <= res_hit_r ? blk_r[2][IDX_W-1:0] : '0;
      out_normal_axis <= res_hit_r ? a_r : 2'd0;
      out_normal_negative <= res_hit_r && (dir_r[a_r] > 0);
      out_hit_x <= res_hit_r ? hp_r[0] : '0;
      out_hit_y <= res_hit_r ? hp_r[1] : '0;
      out_hit_z <= res_hit_r ? hp_r[2] : '0;
    end
  end

endmodule

### sv/vrt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences clearing, division, walking and result beats.
module vrt_ctrl import vrt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_operation,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic [2:0] div_idx_r, div_idx_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    div_idx_nxt = div_idx_r;
    ax_nxt = ax_r;
    unique case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept && in_operation == OP_CAST) begin
          state_nxt = S_DLOAD;
          div_idx_nxt = 3'd0;
        end
      end
      S_DLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (stat.div_last) begin
          if (div_idx_r == DIV_LAST) begin
            state_nxt = S_STEP;
          end else begin
            div_idx_nxt = div_idx_r + 3'd1;
            state_nxt = S_DLOAD;
          end
        end
      end
      S_STEP: state_nxt = stat.walk_stop ? S_DONE : S_READ;
      S_READ: state_nxt = S_TEST;
      S_TEST: begin
        if (stat.is_hit) begin
          state_nxt = S_MUL;
          ax_nxt = 2'd0;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: begin
        if (ax_r == AX_LAST) begin
          state_nxt = S_DONE;
        end else begin
          ax_nxt = ax_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_idx = div_idx_r;
    cmd.ax = ax_r;
    in_ready = state_r == S_IDLE;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.wr_voxel = accept && in_operation == OP_WRITE;
        cmd.cast_load = accept && in_operation == OP_CAST;
      end
      S_DLOAD: cmd.div_load = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_STEP: cmd.walk_step = !stat.walk_stop;
      S_READ: cmd.mem_read = 1'b1;
      S_TEST: cmd.test = 1'b1;
      S_MUL: cmd.mul = 1'b1;
      S_ADD: cmd.add = 1'b1;
      S_DONE: cmd.out_load = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      div_idx_r <= 3'd0;
      ax_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      div_idx_r <= div_idx_nxt;
      ax_r <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_walk_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |=> state_r == S_READ)
    else $error("walk step not followed by memory read");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_div_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_idx_r <= DIV_LAST && ax_r <= AX_LAST)
    else $error("sequencer counter out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR || state_r == S_DIV) |-> !accept)
    else $error("beat accepted while busy");

endmodule

### sv/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Top level of the voxel ray traversal block.
// Usage: the input channel carries one beat per item. A write beat
// (operation 0) stores one voxel of the occupancy map and gives no result.
// A cast beat (operation 1) walks the ray through the map and gives one
// result beat on the output channel. The user must set the reach limit
// through cfg_wr_en and cfg_wr_data only while the block is idle; the block
// itself does not enforce this.
// Sequence: a write stores its voxel when accepted. A cast runs six serial
// divisions, each after a load step, then steps through voxels (step, memory
// read, test), then on a hit runs the hit point multiplier, then loads the
// result. The serial divider and one read port serve one cast at a time.
// Reset: the map is cleared by a pass over all its GRID_SIZE^3 cells; no beat
// is taken before it ends. The reach limit returns to 327680.
// Stall: the result sits in an output register. While it waits, new beats are
// accepted; a cast that finishes meanwhile holds in its done state, with the
// input closed, until the output register is free.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_operation,
  input  logic [IDX_W-1:0]        in_voxel_x,
  input  logic [IDX_W-1:0]        in_voxel_y,
  input  logic [IDX_W-1:0]        in_voxel_z,
  input  logic                    in_solid,
  input  logic signed [ORG_W-1:0] in_origin_x,
  input  logic signed [ORG_W-1:0] in_origin_y,
  input  logic signed [ORG_W-1:0] in_origin_z,
  input  logic signed [DIR_W-1:0] in_dir_x,
  input  logic signed [DIR_W-1:0] in_dir_y,
  input  logic signed [DIR_W-1:0] in_dir_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [IDX_W-1:0]        out_block_x,
  output logic [IDX_W-1:0]        out_block_y,
  output logic [IDX_W-1:0]        out_block_z,
  output logic [1:0]              out_normal_axis,
  output logic                    out_normal_negative,
  output logic signed [ORG_W-1:0] out_hit_x,
  output logic signed [ORG_W-1:0] out_hit_y,
  output logic signed [ORG_W-1:0] out_hit_z,
  input  logic                    cfg_wr_en,
  input  logic [REACH_W-1:0]      cfg_wr_data
);

  cmd_t cmd;
  stat_t stat;

  vrt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  vrt_datapath #(
    .GRID_SIZE     (GRID_SIZE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_voxel_x          (in_voxel_x),
    .in_voxel_y          (in_voxel_y),
    .in_voxel_z          (in_voxel_z),
    .in_solid            (in_solid),
    .in_origin_x         (in_origin_x),
    .in_origin_y         (in_origin_y),
    .in_origin_z         (in_origin_z),
    .in_dir_x            (in_dir_x),
    .in_dir_y            (in_dir_y),
    .in_dir_z            (in_dir_z),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_hit             (out_hit),
    .out_block_x         (out_block_x),
    .out_block_y         (out_block_y),
    .out_block_z         (out_block_z),
    .out_normal_axis     (out_normal_axis),
    .out_normal_negative (out_normal_negative),
    .out_hit_x           (out_hit_x),
    .out_hit_y           (out_hit_y),
    .out_hit_z           (out_hit_z)
  );

endmodule

### tb/tb_voxel_ray_traversal.sv
`timescale 1ns / 1ps
// Self-checking testbench of voxel_ray_traversal with its own ray walk predictor.
module tb_voxel_ray_traversal;
  import vrt_pkg::*;

  localparam int UNIT = 65536;
  localparam int IDLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        voxel_x;
    logic [IDX_W-1:0]        voxel_y;
    logic [IDX_W-1:0]        voxel_z;
    logic                    solid;
    logic [ORG_W-1:0]        origin_x;
    logic [ORG_W-1:0]        origin_y;
    logic [ORG_W-1:0]        origin_z;
    logic [DIR_W-1:0]        dir_x;
    logic [DIR_W-1:0]        dir_y;
    logic [DIR_W-1:0]        dir_z;
  } ray_item_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] block_x;
    logic [IDX_W-1:0] block_y;
    logic [IDX_W-1:0] block_z;
    logic [1:0]       normal_axis;
    logic             normal_negative;
    logic [ORG_W-1:0] hit_x;
    logic [ORG_W-1:0] hit_y;
    logic [ORG_W-1:0] hit_z;
  } ray_hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic [IDX_W-1:0] in_voxel_x = '0, in_voxel_y = '0, in_voxel_z = '0;
  logic in_solid = 1'b0;
  logic signed [ORG_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [IDX_W-1:0] out_block_x, out_block_y, out_block_z;
  logic [1:0] out_normal_axis;
  logic out_normal_negative;
  logic signed [ORG_W-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic cfg_wr_en = 1'b0;
  logic [REACH_W-1:0] cfg_wr_data = '0;

  ray_item_t cast_queue[$];
  ray_hit_t hits_due[$];
  bit voxel_map [0:262143];
  logic [REACH_W-1:0] reach_limit;
  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  voxel_ray_traversal #(
    .GRID_SIZE(64),
    .FRACTION_BITS(16)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation),
    .in_voxel_x(in_voxel_x), .in_voxel_y(in_voxel_y), .in_voxel_z(in_voxel_z),
    .in_solid(in_solid),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit),
    .out_block_x(out_block_x), .out_block_y(out_block_y), .out_block_z(out_block_z),
    .out_normal_axis(out_normal_axis), .out_normal_negative(out_normal_negative),
    .out_hit_x(out_hit_x), .out_hit_y(out_hit_y), .out_hit_z(out_hit_z),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic bit axis_closer(bit fin[3], longint t[3], int i, int j);
    return fin[i] && (!fin[j] || t[i] < t[j]);
  endfunction

  function automatic bit voxel_solid(longint b[3]);
    for (int k = 0; k < 3; k++) begin
      if (b[k] < 0 || b[k] > 63) return 1'b0;
    end
    return voxel_map[{b[0][5:0], b[1][5:0], b[2][5:0]}];
  endfunction

  function automatic ray_hit_t walk_ray(ray_item_t it);
    longint org[3], dir[3], blk[3], stp[3], tmax[3], tdel[3];
    longint frac, ad, t_entry, p, h;
    bit fin[3];
    int a;
    bit done;
    ray_hit_t r;
    r = '0;
    org[0] = longint'($signed(it.origin_x));
    org[1] = longint'($signed(it.origin_y));
    org[2] = longint'($signed(it.origin_z));
    dir[0] = longint'($signed(it.dir_x));
    dir[1] = longint'($signed(it.dir_y));
    dir[2] = longint'($signed(it.dir_z));
    for (int k = 0; k < 3; k++) begin
      frac = org[k] & (UNIT - 1);
      blk[k] = (org[k] - frac) >>> 16;
      fin[k] = dir[k] != 0;
      stp[k] = 0;
      tmax[k] = 0;
      tdel[k] = 0;
      if (fin[k]) begin
        ad = dir[k] < 0 ? -dir[k] : dir[k];
        if (dir[k] > 0) begin
          stp[k] = 1;
          tmax[k] = ((UNIT - frac) << 14) / ad;
        end else begin
          stp[k] = -1;
          tmax[k] = (frac << 14) / ad;
        end
        tdel[k] = (longint'(UNIT) << 14) / ad;
      end
    end
    done = 1'b0;
    while (!done) begin
      if (axis_closer(fin, tmax, 0, 1) && axis_closer(fin, tmax, 0, 2)) a = 0;
      else if (axis_closer(fin, tmax, 1, 2)) a = 1;
      else if (fin[2]) a = 2;
      else a = 3;
      if (a == 3) begin
        done = 1'b1;
      end else if (tmax[a] > longint'(reach_limit)) begin
        done = 1'b1;
      end else begin
        t_entry = tmax[a];
        blk[a] += stp[a];
        tmax[a] += tdel[a];
        if (voxel_solid(blk)) begin
          r.hit = 1'b1;
          r.block_x = blk[0][5:0];
          r.block_y = blk[1][5:0];
          r.block_z = blk[2][5:0];
          r.normal_axis = 2'(a);
          r.normal_negative = stp[a] > 0;
          for (int k = 0; k < 3; k++) begin
            p = dir[k] * t_entry + 8192;
            h = org[k] + (p >>> 14);
            if (h > 8388607) h = 8388607;
            if (h < -8388608) h = -8388608;
            if (k == 0) r.hit_x = h[23:0];
            else if (k == 1) r.hit_y = h[23:0];
            else r.hit_z = h[23:0];
          end
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic ray_item_t voxel_write(int x, int y, int z, bit s);
    ray_item_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.voxel_x = x[5:0];
    it.voxel_y = y[5:0];
    it.voxel_z = z[5:0];
    it.solid = s;
    return it;
  endfunction

  function automatic ray_item_t ray_cast(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_item_t it;
    it = '0;
    it.operation = OP_CAST;
    it.voxel_x = 6'($urandom);
    it.voxel_y = 6'($urandom);
    it.voxel_z = 6'($urandom);
    it.solid = 1'($urandom);
    it.origin_x = ox[23:0];
    it.origin_y = oy[23:0];
    it.origin_z = oz[23:0];
    it.dir_x = dx[15:0];
    it.dir_y = dy[15:0];
    it.dir_z = dz[15:0];
    return it;
  endfunction

  function automatic int rand_origin();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return int'($urandom);
    if (pick == 1) return -int'($urandom_range(1, 3 * UNIT));
    if (pick == 2) return $urandom_range(0, 11) * UNIT;
    return $urandom_range(0, 11) * UNIT + $urandom_range(0, UNIT - 1);
  endfunction

  function automatic int rand_dir();
    int pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return 0;
    if (pick == 1) return 16384;
    if (pick == 2) return -16384;
    if (pick == 3) return int'($urandom) % 32768;
    if (pick == 4) return ($urandom_range(0, 1) != 0) ? 11585 : -11585;
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic ray_item_t rand_item();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 9) == 0) begin
        return voxel_write($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63), 1'($urandom));
      end
      return voxel_write($urandom_range(0, 11), $urandom_range(0, 11),
                         $urandom_range(0, 11), $urandom_range(0, 3) != 0);
    end
    return ray_cast(rand_origin(), rand_origin(), rand_origin(),
                    rand_dir(), rand_dir(), rand_dir());
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cast_queue.size() != 0 || in_valid || hits_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reach(logic [REACH_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reach_limit = value;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) cast_queue.push_back(rand_item());
  endtask

  // Driver: a beat is predicted when accepted, then the next item or a gap is chosen.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_operation == OP_WRITE) begin
          voxel_map[{in_voxel_x, in_voxel_y, in_voxel_z}] = in_solid;
        end else begin
          hits_due.push_back(walk_ray({in_operation, in_voxel_x, in_voxel_y, in_voxel_z,
            in_solid, in_origin_x, in_origin_y, in_origin_z, in_dir_x, in_dir_y,
            in_dir_z}));
        end
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (cast_queue.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (cast_queue.size() != 0) begin
        {in_operation, in_voxel_x, in_voxel_y, in_voxel_z, in_solid, in_origin_x,
         in_origin_y, in_origin_z, in_dir_x, in_dir_y, in_dir_z} <= cast_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat and drives the receiver's stalls.
  always @(posedge clk) begin
    ray_hit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        $display("result beat with nothing expected at %0t", $realtime);
        errors++;
      end else begin
        want = hits_due.pop_front();
        if (out_hit != want.hit) report("hit", out_hit, want.hit);
        if (out_block_x != want.block_x) report("block_x", out_block_x, want.block_x);
        if (out_block_y != want.block_y) report("block_y", out_block_y, want.block_y);
        if (out_block_z != want.block_z) report("block_z", out_block_z, want.block_z);
        if (out_normal_axis != want.normal_axis)
          report("normal_axis", out_normal_axis, want.normal_axis);
        if (out_normal_negative != want.normal_negative)
          report("normal_negative", out_normal_negative, want.normal_negative);
        if (out_hit_x != want.hit_x) report("hit_x", out_hit_x, want.hit_x);
        if (out_hit_y != want.hit_y) report("hit_y", out_hit_y, want.hit_y);
        if (out_hit_z != want.hit_z) report("hit_z", out_hit_z, want.hit_z);
      end
    end
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("voxel_ray_traversal regression: fail");
      $finish;
    end
  end

  initial begin
    reach_limit = REACH_RESET;
    for (int i = 0; i < 262144; i++) voxel_map[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    cast_queue.push_back(voxel_write(5, 3, 2, 1'b1));
    cast_queue.push_back(ray_cast(163840, 229376, 163840, 16384, 0, 0));
    cast_queue.push_back(voxel_write(1, 3, 2, 1'b1));
    cast_queue.push_back(ray_cast(294912, 229376, 163840, -16384, 0, 0));
    cast_queue.push_back(voxel_write(2, 6, 2, 1'b1));
    cast_queue.push_back(ray_cast(163840, 7 * UNIT, 163840, 0, -16384, 0));
    cast_queue.push_back(voxel_write(2, 3, 5, 1'b1));
    cast_queue.push_back(ray_cast(163840, 229376, 163840, 0, 0, 16384));
    cast_queue.push_back(ray_cast(32768, 32768, 32768, 11585, 11585, 11585));
    cast_queue.push_back(ray_cast(163840, 163840, 163840, 0, 0, 0));
    cast_queue.push_back(ray_cast(8388607, -8388608, 0, -16384, 16384, 1));
    cast_queue.push_back(ray_cast(-8388608, 8388607, -1, 16384, -16384, -1));
    cast_queue.push_back(voxel_write(63, 63, 63, 1'b1));
    cast_queue.push_back(voxel_write(0, 0, 0, 1'b1));
    cast_queue.push_back(ray_cast(-32768, 32768, 32768, 16384, 0, 0));
    cast_queue.push_back(ray_cast(64 * UNIT + 32768, 63 * UNIT + 32768, 63 * UNIT + 32768,
                                  -16384, 0, 0));
    cast_queue.push_back(ray_cast(32768, 32768, 32768, -32768, 32767, 1));
    cast_queue.push_back(voxel_write(0, 0, 0, 1'b0));
    cast_queue.push_back(ray_cast(-32768, 32768, 32768, 16384, 0, 0));

    set_reach('0);
    cast_queue.push_back(ray_cast(163840, 7 * UNIT, 163840, 0, -16384, 0));
    cast_queue.push_back(ray_cast(163840, 229376, 163840, 16384, 0, 0));
    queue_random(40);

    set_reach(23'h7FFFFF);
    queue_random(80);
    wait_drained();
    queue_random(40);
    @(negedge clk);
    hold_go = 1'b1;

    set_reach(23'($urandom_range(65536, 1500000)));
    queue_random(80);
    set_reach(23'($urandom_range(1, 65535)));
    queue_random(50);
    set_reach(23'd1000000);
    queue_random(80);

    set_reach(REACH_RESET);
    quiet = 1'b1;
    queue_random(60);
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("voxel_ray_traversal regression: pass");
    end else begin
      $display("voxel_ray_traversal regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
sv/vrt_pkg.sv
sv/vrt_datapath.sv
sv/vrt_ctrl.sv
sv/voxel_ray_traversal.sv
tb/tb_voxel_ray_traversal.sv
